>>> rtl/sorted_priority_queue_assert.svh
// Assertion macros used by the checker file of the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_priority_queue check failed");

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_priority_queue check failed");

`endif

>>> rtl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNDERFLOW = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] entry_value;
        logic signed [31:0] entry_priority;
    } req_t;

    typedef struct packed {
        logic signed [31:0] removed_value;
        status_t            status;
        logic        [4:0]  entry_count;
    } rsp_t;

    // One stored queue entry.
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } entry_t;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic   insert;
        logic   remove;
        entry_t new_entry;
    } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic      clk,
    input  wire cell_ctl_t ctl,
    input  wire logic      occupied,
    input  wire logic      at_tail,
    input  wire logic      left_greater,
    input  wire entry_t    left_entry,
    input  wire entry_t    right_entry,
    output logic           greater,
    output entry_t         entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // An occupied cell whose priority is strictly larger than the new one
    // must move one place toward the tail, which keeps equal priorities in
    // arrival order.
    assign greater = occupied && (entry_reg.prio > ctl.new_entry.prio);
    assign entry   = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.insert && (greater || at_tail))
        begin
            entry_next = left_greater ? left_entry : ctl.new_entry;
        end
        else if (ctl.remove)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

>>> rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted priority queue holding up to CAPACITY entries, smallest priority first.
// Request channel (req_valid, req_stall, req): each transfer is an insert
// (mode 0, value and priority) or a delete of the head entry (mode 1).
// Response channel (rsp_valid, rsp_stall, rsp): exactly one response per
// request, with the removed value, a status (ok, underflow, full) and the
// entry count after the request.
// The response to a transferred request appears in the cycle after the transfer.
// The queue takes one request per cycle while req_stall is low, a rate set by the
// row of compare-and-shift cells, which all update together in the same cycle.
// Entries of equal priority leave in arrival order.
// The response sits in an output register. While the receiver stalls a held
// response, req_stall is raised and the queue state does not change.
// Reset clears the entry count and the response valid flag; stored entries
// are not cleared, since only slots below the count are ever read.

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic             accept;
    logic             is_insert;
    logic             full;
    logic             empty;
    cell_ctl_t        ctl;

    logic   [CAPACITY-1:0] occupied;
    logic   [CAPACITY-1:0] at_tail;
    logic   [CAPACITY-1:0] greater;
    entry_t                cell_entry [CAPACITY];

    logic [CNT_W+4:0] count_wide;

    // A new request is taken unless a response is waiting on a stalled receiver.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign is_insert = (req.mode == MODE_INSERT);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);

    assign ctl.insert          = accept && is_insert && !full;
    assign ctl.remove          = accept && !is_insert && !empty;
    assign ctl.new_entry.value = req.entry_value;
    assign ctl.new_entry.prio  = req.entry_priority;

    // Slot 0 is the head. Each cell knows whether it holds a live entry and
    // whether it is the first free slot, where an insert lands when no live
    // entry has a larger priority.
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            assign occupied[i] = (CNT_W'(i) < count_reg);
            assign at_tail[i]  = (CNT_W'(i) == count_reg);

            if (i == 0)
            begin : g_head
                spq_cell u_cell (
                    .clk          (clk),
                    .ctl          (ctl),
                    .occupied     (occupied[i]),
                    .at_tail      (at_tail[i]),
                    .left_greater (1'b0),
                    .left_entry   (ctl.new_entry),
                    .right_entry  (cell_entry[(i + 1) % CAPACITY]),
                    .greater      (greater[i]),
                    .entry        (cell_entry[i])
                );
            end
            else if (i == CAPACITY - 1)
            begin : g_last
                // The last slot has no right neighbor; after a delete it is
                // beyond the count, so its contents do not matter.
                spq_cell u_cell (
                    .clk          (clk),
                    .ctl          (ctl),
                    .occupied     (occupied[i]),
                    .at_tail      (at_tail[i]),
                    .left_greater (greater[i - 1]),
                    .left_entry   (cell_entry[i - 1]),
                    .right_entry  (cell_entry[i]),
                    .greater      (greater[i]),
                    .entry        (cell_entry[i])
                );
            end
            else
            begin : g_mid
                spq_cell u_cell (
                    .clk          (clk),
                    .ctl          (ctl),
                    .occupied     (occupied[i]),
                    .at_tail      (at_tail[i]),
                    .left_greater (greater[i - 1]),
                    .left_entry   (cell_entry[i - 1]),
                    .right_entry  (cell_entry[i + 1]),
                    .greater      (greater[i]),
                    .entry        (cell_entry[i])
                );
            end
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctl.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // The reported count is the internal count reduced to five bits.
    assign count_wide = {5'b0, count_next};

    always_comb
    begin
        rsp_next.removed_value = ctl.remove ? cell_entry[0].value : 32'sd0;
        rsp_next.entry_count   = count_wide[4:0];
        if (is_insert && full)
        begin
            rsp_next.status = STATUS_FULL;
        end
        else if (!is_insert && empty)
        begin
            rsp_next.status = STATUS_UNDERFLOW;
        end
        else
        begin
            rsp_next.status = STATUS_OK;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

>>> rtl/spq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_priority_queue_assert.svh"

module spq_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_stall,
    input wire req_t req,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire rsp_t rsp
);

    localparam logic [4:0] CAP_LOW = 5'(CAPACITY % 32);

    // A stalled response stays valid and unchanged.
    `SPQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // Every request transfer gives a response in the next cycle.
    `SPQ_ASSERT_NEXT(a_rsp_follows, clk, rst_n, req_valid && !req_stall, rsp_valid)

    // An underflow only happens on an empty queue and returns no value.
    `SPQ_ASSERT_SAME(a_underflow, clk, rst_n, rsp_valid && rsp.status == STATUS_UNDERFLOW, rsp.entry_count == 5'd0 && rsp.removed_value == 32'sd0)

    // A dropped insert reports a full queue.
    `SPQ_ASSERT_SAME(a_full, clk, rst_n, rsp_valid && rsp.status == STATUS_FULL, rsp.entry_count == CAP_LOW && rsp.removed_value == 32'sd0)

    // The request side is held off exactly while a response waits on the receiver.
    `SPQ_ASSERT_SAME(a_stall_src, clk, rst_n, req_stall, rsp_valid && rsp_stall)

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);

`default_nettype wire
